// ===== rtl/assert_macros.svh =====
// Assertion macros for the reassembly tracker RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/srrt_pkg.sv =====
// Package for the stream reassembly range tracker: constants, codes and types.
// Used by the tracker top, srrt_list and the testbench.
`timescale 1ns / 1ps
package srrt_pkg;
    localparam int MAX_RANGES_DEF  = 64;
    localparam int OFFSET_BITS_DEF = 62;
    localparam int WIN_BITS        = 21;
    localparam int LEN_BITS        = 16;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 21'd65536;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_REJECT   = 1'b1;

    typedef struct packed {
        logic start;
        logic add;
    } t_pass_ctl;

    typedef struct packed {
        logic done;
    } t_pass_sts;
endpackage

// ===== rtl/stream_reassembly_range_tracker.sv =====
// Channel  | group           | content
// input    | i_s_* / o_s_*   | tuser: mode; tdata: seg_offset, length
// output   | o_m_* / i_m_*   | tdata: status, range_dropped, read_count, read_start,
//          |                 |        bytes_available, edge_offset
// config   | i_cfg_we/wdata  | window_size
// A read, and an insert that leaves the range list alone, passes through the check, decide
// and output states before its result is registered; the next word is taken back in idle.
// An insert that runs a pass adds the launch and pass states before the output state; the
// pass reads every stored range from list memory and places the new range on an add.
// One word is in flight at a time; a result waiting on i_m_tready holds the input.
// Reset (synchronous, active low) clears edge, read offset and list count.
// Uses srrt_pkg, srrt_list.
`timescale 1ns / 1ps
module stream_reassembly_range_tracker import srrt_pkg::*; #(
    parameter int MAX_RANGES  = MAX_RANGES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // seg_offset, length
    input  logic [((OFFSET_BITS+LEN_BITS+7)/8)*8-1:0] i_s_tdata,
    // mode
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // status, range_dropped, read_count, read_start, bytes_available, edge_offset
    output logic [((2*OFFSET_BITS+2+LEN_BITS+WIN_BITS+7)/8)*8-1:0] o_m_tdata,
    input  logic                i_cfg_we,
    input  logic [WIN_BITS-1:0] i_cfg_wdata
);
    localparam int OB       = OFFSET_BITS;
    localparam int CW       = $clog2(MAX_RANGES + 1);
    localparam int OUT_USED = 2 * OB + 2 + LEN_BITS + WIN_BITS;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_CHECK  = 3'd1;
    localparam logic [2:0] T_DECIDE = 3'd2;
    localparam logic [2:0] T_LAUNCH = 3'd3;
    localparam logic [2:0] T_PASS   = 3'd4;
    localparam logic [2:0] T_OUT    = 3'd5;

    logic [2:0]          r_state, n_state;
    logic                r_mode;
    logic [OB-1:0]       r_off;
    logic [LEN_BITS-1:0] r_len;
    logic [OB:0]         r_end, r_lim;
    logic [OB-1:0]       r_avail;
    logic                r_status, r_drop, r_add;
    logic [LEN_BITS-1:0] r_grant;
    logic [OB-1:0]       r_rstart;
    logic [OB-1:0]       r_edge, n_edge;
    logic [OB-1:0]       r_rp;
    logic [WIN_BITS-1:0] r_win;
    logic                r_ovld;
    logic [OUT_W-1:0]    r_odata, n_odata;

    t_pass_ctl           w_ctl;
    t_pass_sts           w_sts;
    logic [OB-1:0]       w_pass_edge;
    logic [CW-1:0]       w_total;
    logic [OB-1:0]       w_end, w_limit, w_len_x, w_avail;
    logic [LEN_BITS-1:0] w_grant;
    logic [WIN_BITS-1:0] w_avail_sat;

    assign w_end   = r_end[OB-1:0];
    assign w_limit = r_lim[OB] ? '1 : r_lim[OB-1:0];
    assign w_len_x = {{(OB-LEN_BITS){1'b0}}, r_len};
    assign w_grant = (w_len_x > r_avail) ? r_avail[LEN_BITS-1:0] : r_len;
    assign w_avail = (r_edge > r_rp) ? r_edge - r_rp : '0;
    assign w_avail_sat = (|w_avail[OB-1:WIN_BITS]) ? '1 : w_avail[WIN_BITS-1:0];

    assign o_s_tready = (r_state == T_IDLE);
    assign w_ctl.start = (r_state == T_LAUNCH);
    assign w_ctl.add   = r_add;

    always_comb begin
        n_state = r_state;
        n_edge  = r_edge;
        n_odata = '0;
        n_odata[OUT_USED-1:0] = {r_edge, w_avail_sat, r_rstart, r_grant, r_drop, r_status};
        case (r_state)
            T_IDLE:   if (i_s_tvalid) n_state = T_CHECK;
            T_CHECK:  n_state = T_DECIDE;
            T_DECIDE: begin
                n_state = T_OUT;
                if ((r_mode == MODE_INSERT) && (r_len != '0) && !r_end[OB] &&
                    (w_end <= w_limit)) begin
                    if ((r_off <= r_edge) && (w_end > r_edge)) begin
                        n_edge  = w_end;
                        n_state = T_LAUNCH;
                    end else if ((r_off > r_edge) && (w_total < CW'(MAX_RANGES))) begin
                        n_state = T_LAUNCH;
                    end
                end
            end
            T_LAUNCH: n_state = T_PASS;
            T_PASS: begin
                if (w_sts.done) begin
                    n_edge  = w_pass_edge;
                    n_state = T_OUT;
                end
            end
            T_OUT:    if (!r_ovld || i_m_tready) n_state = T_IDLE;
            default:  n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_edge  <= '0;
            r_rp    <= '0;
            r_win   <= WIN_RESET;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            if ((r_state == T_DECIDE) && (r_mode == MODE_READ)) begin
                r_rp <= r_rp + {{(OB-LEN_BITS){1'b0}}, w_grant};
            end
            if ((r_state == T_OUT) && (!r_ovld || i_m_tready)) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
        if (o_s_tready && i_s_tvalid) begin
            r_mode   <= i_s_tuser;
            r_off    <= i_s_tdata[OB-1:0];
            r_len    <= i_s_tdata[OB+LEN_BITS-1:OB];
            r_rstart <= r_rp;
        end
        if (r_state == T_CHECK) begin
            r_end   <= {1'b0, r_off} + {{(OB+1-LEN_BITS){1'b0}}, r_len};
            r_lim   <= {1'b0, r_rp} + {{(OB+1-WIN_BITS){1'b0}}, r_win};
            r_avail <= w_avail;
        end
        if (r_state == T_DECIDE) begin
            r_status <= ST_OK;
            r_drop   <= 1'b0;
            r_grant  <= '0;
            r_add    <= (r_off > r_edge);
            if (r_mode == MODE_READ) begin
                r_grant <= w_grant;
            end else if (r_len != '0) begin
                if (r_end[OB] || (w_end > w_limit)) begin
                    r_status <= ST_REJECT;
                end else if ((r_off > r_edge) && (w_total >= CW'(MAX_RANGES))) begin
                    r_drop <= 1'b1;
                end
            end
        end
        if ((r_state == T_OUT) && (!r_ovld || i_m_tready)) begin
            r_odata <= n_odata;
        end
    end

    srrt_list #(
        .MAX_RANGES  (MAX_RANGES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_new_s (r_off),
        .i_new_e (w_end),
        .i_edge  (r_edge),
        .o_sts   (w_sts),
        .o_edge  (w_pass_edge),
        .o_total (w_total)
    );

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_odata;
endmodule

// ===== rtl/srrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module srrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/srrt_list.sv =====
// Range list engine: one streaming pass over the stored ranges that places a
// new range, merges, absorbs into the edge and compacts. Uses srrt_pkg, srrt_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srrt_list import srrt_pkg::*; #(
    parameter int MAX_RANGES  = MAX_RANGES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_pass_ctl                       i_ctl,
    input  logic [OFFSET_BITS-1:0]          i_new_s,
    input  logic [OFFSET_BITS-1:0]          i_new_e,
    input  logic [OFFSET_BITS-1:0]          i_edge,
    output t_pass_sts                       o_sts,
    output logic [OFFSET_BITS-1:0]          o_edge,
    output logic [$clog2(MAX_RANGES+1)-1:0] o_total
);
    localparam int OB = OFFSET_BITS;
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic L_IDLE = 1'b0;
    localparam logic L_SCAN = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_wp, n_wp;
    logic          r_new_pend, n_new_pend;
    logic [OB-1:0] r_new_s, n_new_s, r_new_e, n_new_e;
    logic          r_cur_vld, n_cur_vld;
    logic [OB-1:0] r_cur_s, n_cur_s, r_cur_e, n_cur_e;
    logic [OB-1:0] r_edge, n_edge;
    logic          r_done, n_done;

    logic            w_re, w_we;
    logic [IW-1:0]   w_raddr, w_waddr;
    logic [2*OB-1:0] w_rdata;
    logic [OB-1:0]   w_rd_s, w_rd_e;
    logic            w_x_vld, w_emit;
    logic [OB-1:0]   w_x_s, w_x_e;
    logic [CW-1:0]   w_cnt_inc;

    assign w_rd_s    = w_rdata[OB-1:0];
    assign w_rd_e    = w_rdata[2*OB-1:OB];
    assign w_cnt_inc = r_cnt + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_cnt      = r_cnt;
        n_wp       = r_wp;
        n_new_pend = r_new_pend;
        n_new_s    = r_new_s;
        n_new_e    = r_new_e;
        n_cur_vld  = r_cur_vld;
        n_cur_s    = r_cur_s;
        n_cur_e    = r_cur_e;
        n_edge     = r_edge;
        n_done     = 1'b0;
        w_re       = 1'b0;
        w_raddr    = '0;
        w_we       = 1'b0;
        w_waddr    = r_wp[IW-1:0];
        w_x_vld    = 1'b0;
        w_x_s      = r_new_s;
        w_x_e      = r_new_e;
        w_emit     = 1'b0;
        case (r_state)
            L_IDLE: begin
                if (i_ctl.start) begin
                    w_re       = 1'b1;
                    n_new_pend = i_ctl.add;
                    n_new_s    = i_new_s;
                    n_new_e    = i_new_e;
                    n_edge     = i_edge;
                    n_cnt      = '0;
                    n_wp       = '0;
                    n_cur_vld  = 1'b0;
                    n_state    = L_SCAN;
                end
            end
            L_SCAN: begin
                // pick the lowest start of next stored range and new range
                if ((r_cnt < r_total) && !(r_new_pend && (r_new_s < w_rd_s))) begin
                    w_x_vld = 1'b1;
                    w_x_s   = w_rd_s;
                    w_x_e   = w_rd_e;
                    w_re    = 1'b1;
                    w_raddr = w_cnt_inc[IW-1:0];
                    n_cnt   = w_cnt_inc;
                end else if (r_new_pend) begin
                    w_x_vld    = 1'b1;
                    n_new_pend = 1'b0;
                end
                if (w_x_vld && r_cur_vld && (w_x_s <= r_cur_e)) begin
                    if (w_x_e > r_cur_e) begin
                        n_cur_e = w_x_e;
                    end
                end else begin
                    w_emit    = r_cur_vld;
                    n_cur_vld = w_x_vld;
                    n_cur_s   = w_x_s;
                    n_cur_e   = w_x_e;
                end
                // absorb into the edge or write back compacted
                if (w_emit) begin
                    if (r_cur_s <= r_edge) begin
                        if (r_cur_e > r_edge) begin
                            n_edge = r_cur_e;
                        end
                    end else begin
                        w_we = 1'b1;
                        n_wp = r_wp + 1'b1;
                    end
                end
                if (!w_x_vld) begin
                    n_total = n_wp;
                    n_done  = 1'b1;
                    n_state = L_IDLE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= L_IDLE;
            r_total   <= '0;
            r_done    <= 1'b0;
            r_cur_vld <= 1'b0;
            r_new_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_done    <= n_done;
            r_cur_vld <= n_cur_vld;
            r_new_pend <= n_new_pend;
        end
        r_cnt   <= n_cnt;
        r_wp    <= n_wp;
        r_new_s <= n_new_s;
        r_new_e <= n_new_e;
        r_cur_s <= n_cur_s;
        r_cur_e <= n_cur_e;
        r_edge  <= n_edge;
    end

    srrt_ram #(
        .WIDTH (2 * OB),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_cur_e, r_cur_s}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_sts.done = r_done;
    assign o_edge     = r_edge;
    assign o_total    = r_total;

    `ASSERT_ALWAYS(a_total_bound, i_clk, i_rst_n, r_total <= CW'(MAX_RANGES), "range count over capacity")
    `ASSERT_ALWAYS(a_wp_behind, i_clk, i_rst_n, (r_state == L_SCAN) |-> (r_wp <= r_cnt + 1'b1), "write pointer overtook read")
    `ASSERT_ALWAYS(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "pass done held")
    `ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_ctl.start && (r_state == L_SCAN), "pass started while busy")
endmodule

// ===== dv/stream_reassembly_range_tracker_test.sv =====
// Testbench for stream_reassembly_range_tracker: a queue-fed driver with bursts and
// gaps, a stalling receiver and a per-word predictor of edge, read offset and ranges.
// Depends on srrt_pkg and the RTL of the block.
`timescale 1ns / 1ps
module stream_reassembly_range_tracker_test import srrt_pkg::*;;

    localparam int NRANGE = MAX_RANGES_DEF;
    localparam logic [63:0] OFF_MAX = (64'd1 << OFFSET_BITS_DEF) - 64'd1;

    typedef struct {
        logic        mode;
        logic [61:0] off;
        logic [15:0] len;
    } t_seg_word;

    typedef struct {
        logic        status;
        logic        dropped;
        logic [15:0] count;
        logic [61:0] start;
        logic [20:0] avail;
        logic [61:0] edge_off;
    } t_track_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [79:0]  i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [167:0] o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic [20:0]  i_cfg_wdata = '0;

    stream_reassembly_range_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // tracker state as predicted
    logic [63:0] win_size = 64'd65536;
    logic [63:0] contig = '0;
    logic [63:0] rd_pos = '0;
    logic [63:0] rng_lo [NRANGE];
    logic [63:0] rng_hi [NRANGE];
    int unsigned rng_cnt = 0;

    t_seg_word  pending_words[$];
    t_track_res expected_res[$];
    int         errors = 0;
    bit         word_taken = 0;
    int         cycle_cnt = 0;

    task automatic settle_ranges();
        int unsigned n, i, o, k;
        logic [63:0] ts, te;
        n = rng_cnt;
        if (n == 0) return;
        for (i = n - 1; i > 0 && rng_lo[i-1] > rng_lo[i]; i--) begin
            ts = rng_lo[i]; te = rng_hi[i];
            rng_lo[i] = rng_lo[i-1]; rng_hi[i] = rng_hi[i-1];
            rng_lo[i-1] = ts; rng_hi[i-1] = te;
        end
        o = 0;
        for (i = 1; i < n; i++) begin
            if (rng_lo[i] <= rng_hi[o]) begin
                if (rng_hi[i] > rng_hi[o]) rng_hi[o] = rng_hi[i];
            end else begin
                o++;
                rng_lo[o] = rng_lo[i]; rng_hi[o] = rng_hi[i];
            end
        end
        n = o + 1;
        k = 0;
        while (k < n && rng_lo[k] <= contig) begin
            if (rng_hi[k] > contig) contig = rng_hi[k];
            k++;
        end
        for (i = 0; i + k < n; i++) begin
            rng_lo[i] = rng_lo[i+k]; rng_hi[i] = rng_hi[i+k];
        end
        rng_cnt = n - k;
    endtask

    task automatic track_word(input t_seg_word w, output t_track_res r);
        logic [63:0] off, len, seg_end, lim, avail;
        off = {2'b0, w.off};
        len = {48'b0, w.len};
        r = '{default: '0};
        r.start = rd_pos[61:0];
        if (w.mode == MODE_INSERT) begin
            if (len != 0) begin
                if (len > OFF_MAX - off) begin
                    r.status = ST_REJECT;
                end else begin
                    seg_end = off + len;
                    lim = (win_size > OFF_MAX - rd_pos) ? OFF_MAX : rd_pos + win_size;
                    if (seg_end > lim) begin
                        r.status = ST_REJECT;
                    end else begin
                        if (off <= contig && seg_end > contig) begin
                            contig = seg_end;
                        end else if (off > contig) begin
                            if (rng_cnt < NRANGE) begin
                                rng_lo[rng_cnt] = off;
                                rng_hi[rng_cnt] = seg_end;
                                rng_cnt++;
                            end else begin
                                r.dropped = 1'b1;
                            end
                        end
                        settle_ranges();
                    end
                end
            end
        end else begin
            avail = (contig > rd_pos) ? contig - rd_pos : 0;
            r.count = (len > avail) ? avail[15:0] : len[15:0];
            rd_pos = rd_pos + {48'b0, r.count};
        end
        avail = (contig > rd_pos) ? contig - rd_pos : 0;
        if (avail > 64'h1FFFFF) avail = 64'h1FFFFF;
        r.avail = avail[20:0];
        r.edge_off = contig[61:0];
    endtask

    // accept side: predict on every taken word, check every delivered word
    always @(posedge i_clk) begin
        t_seg_word  w;
        t_track_res want, got;
        if (i_rst_n) begin
            cycle_cnt <= cycle_cnt + 1;
            if (i_s_tvalid && o_s_tready) begin
                w.mode = i_s_tuser;
                w.off = i_s_tdata[61:0];
                w.len = i_s_tdata[77:62];
                track_word(w, want);
                expected_res.push_back(want);
                word_taken = 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.status = o_m_tdata[0];
                got.dropped = o_m_tdata[1];
                got.count = o_m_tdata[17:2];
                got.start = o_m_tdata[79:18];
                got.avail = o_m_tdata[100:80];
                got.edge_off = o_m_tdata[162:101];
                if (expected_res.size() == 0) begin
                    errors++;
                    $display("%0t unexpected word: expected none actual %p", $realtime, got);
                end else begin
                    want = expected_res.pop_front();
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t status: expected %0h actual %0h",
                                 $realtime, want.status, got.status);
                    end
                    if (got.dropped !== want.dropped) begin
                        errors++;
                        $display("%0t range_dropped: expected %0h actual %0h",
                                 $realtime, want.dropped, got.dropped);
                    end
                    if (got.count !== want.count) begin
                        errors++;
                        $display("%0t read_count: expected %0h actual %0h",
                                 $realtime, want.count, got.count);
                    end
                    if (got.start !== want.start) begin
                        errors++;
                        $display("%0t read_start: expected %0h actual %0h",
                                 $realtime, want.start, got.start);
                    end
                    if (got.avail !== want.avail) begin
                        errors++;
                        $display("%0t bytes_available: expected %0h actual %0h",
                                 $realtime, want.avail, got.avail);
                    end
                    if (got.edge_off !== want.edge_off) begin
                        errors++;
                        $display("%0t edge_offset: expected %0h actual %0h",
                                 $realtime, want.edge_off, got.edge_off);
                    end
                end
            end
        end
    end

    // sender: bursts of random length, random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_seg_word w;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || word_taken) begin
            word_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                i_s_tuser <= w.mode;
                i_s_tdata <= {2'b0, w.len, w.off};
                i_s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: alternating free and stalling stretches, one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else if (cycle_cnt >= 3000 && cycle_cnt < 3600)
            i_m_tready <= 1'b0;
        else if (cycle_cnt[8])
            i_m_tready <= ($urandom_range(0, 3) != 0);
        else if (cycle_cnt[7])
            i_m_tready <= ($urandom_range(0, 9) == 0);
        else
            i_m_tready <= 1'b1;
    end

    task automatic add_word(input logic mode, input logic [63:0] off, input logic [15:0] len);
        t_seg_word w;
        w.mode = mode;
        w.off = off[61:0];
        w.len = len;
        pending_words.push_back(w);
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || i_s_tvalid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (NRANGE + 20) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [20:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        win_size = {43'b0, val};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_batch(input int cnt);
        logic [63:0] base, off;
        int k, sel;
        base = contig;
        for (k = 0; k < cnt; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                off = base + $urandom_range(0, 3000);
                if ($urandom_range(0, 4) == 0 && off > 600) off = off - 600;
                add_word(MODE_INSERT, off,
                         16'(($urandom_range(0, 19) == 0) ? $urandom
                                                           : $urandom_range(1, 900)));
            end else if (sel < 85) begin
                add_word(MODE_READ, {$urandom, $urandom},
                         16'(($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(0, 3000)));
            end else if (sel < 92) begin
                add_word(MODE_INSERT, {$urandom, $urandom}, 16'($urandom));
            end else begin
                add_word(MODE_INSERT, base + $urandom_range(0, 50), 16'd0);
            end
        end
    endtask

    task automatic fill_list();
        int k;
        logic [63:0] base;
        add_word(MODE_READ, 0, 16'hFFFF);
        drain();
        base = contig;
        for (k = 0; k < NRANGE + 2; k++)
            add_word(MODE_INSERT, base + 2 + 3 * k + $urandom_range(0, 1), 16'd1);
        add_word(MODE_INSERT, base, 16'd2);
        add_word(MODE_INSERT, base + 1, 16'd400);
    endtask

    initial begin
        logic [20:0] wins [6];
        int b;
        wins = '{21'd65536, 21'd1, 21'd0, 21'h1FFFFF, 21'd300, 21'd65536};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_window(WIN_RESET);

        // directed: extremes, overflow, window reject, merges, absorb
        add_word(MODE_INSERT, OFF_MAX, 16'd0);
        add_word(MODE_INSERT, OFF_MAX, 16'd1);
        add_word(MODE_INSERT, OFF_MAX - 64'hFFFF, 16'hFFFF);
        add_word(MODE_READ, 0, 16'd5);
        add_word(MODE_INSERT, 64'd100, 16'd10);
        add_word(MODE_INSERT, 64'd50, 16'd50);
        add_word(MODE_INSERT, 64'd300, 16'd20);
        add_word(MODE_INSERT, 64'd0, 16'd50);
        add_word(MODE_INSERT, 64'd10, 16'd20);
        add_word(MODE_INSERT, 64'd310, 16'd5);
        add_word(MODE_INSERT, 64'd280, 16'd1);
        add_word(MODE_INSERT, 64'd110, 16'd170);
        add_word(MODE_INSERT, 64'd0, 16'hFFFF);
        add_word(MODE_INSERT, 64'd65530, 16'd10);
        add_word(MODE_READ, 0, 16'hFFFF);
        add_word(MODE_READ, 0, 16'd0);
        add_word(MODE_READ, 0, 16'd10);
        add_word(MODE_INSERT, 64'd65535, 16'hFFFF);
        add_word(MODE_INSERT, 64'd65535, 16'hFFFE);
        add_word(MODE_READ, OFF_MAX, 16'hFFFF);
        add_word(MODE_READ, 0, 16'd1);
        drain();

        for (b = 0; b < 42; b++) begin
            if (b % 7 == 0) begin
                drain();
                set_window(wins[(b / 7) % 6]);
            end
            if (b % 7 == 3 && win_size > 64'd1000)
                fill_list();
            random_batch(36);
        end
        drain();
        set_window(21'd1048576);
        random_batch(30);
        drain();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/srrt_pkg.sv
rtl/srrt_ram.sv
rtl/srrt_list.sv
rtl/stream_reassembly_range_tracker.sv
dv/stream_reassembly_range_tracker_test.sv
